[rtl/core/bedbm_pkg.sv]
// ----------------------------------------------------------------------------
// bedbm_pkg
// shared constants, types and helpers of the bounded edit distance matcher
// ----------------------------------------------------------------------------
package bedbm_pkg;

   localparam int MAX_LEN = 256;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int LEN_W   = $clog2(MAX_LEN + 2);
   localparam int DP_W    = $clog2(MAX_LEN + 3);
   localparam int LIM_W   = $clog2((MAX_LEN + 2) / 3 + 1);
   localparam int NB_W    = IDX_W + 1;

   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_CAND   = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;

   localparam logic [7:0] CH_UNDER = 8'h5f;

   localparam int INV_LEN = 12;
   localparam int OPR_LEN = 8;

   localparam logic [7:0] INV_PREFIX [INV_LEN] = '{
      8'h5f, 8'h5f, 8'h69, 8'h6e, 8'h76, 8'h65, 8'h6e, 8'h74, 8'h65, 8'h64, 8'h5f, 8'h5f
   };
   localparam logic [7:0] OPR_PREFIX [OPR_LEN] = '{
      8'h6f, 8'h70, 8'h65, 8'h72, 8'h61, 8'h74, 8'h6f, 8'h72
   };

   typedef enum logic [1:0] {
      IDLE_S,
      FLAG_S,
      SWEEP_S,
      COMMIT_S
   } state_type;

   typedef struct packed {
      logic            tok;
      logic [DP_W-1:0] left;
      logic [DP_W-1:0] diag;
      logic [DP_W-1:0] rmin;
   } link_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

[rtl/core/bedbm_cell.sv]
// ----------------------------------------------------------------------------
// bedbm_cell
// one column of the edit distance row: query byte, row value, min forwarding
// ----------------------------------------------------------------------------
module bedbm_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bedbm_pkg::DP_W-1:0]      index,
   input  logic                            qwr_en,
   input  logic [bedbm_pkg::IDX_W-1:0]     qwr_idx,
   input  logic                            qclr,
   input  logic [7:0]                      qwr_data,
   input  logic                            init,
   input  logic [7:0]                      cand_char,
   input  bedbm_pkg::link_type             link_in,
   output bedbm_pkg::link_type             link_out
);

   logic [7:0]                 q_ff;
   logic                       valid_ff;
   logic                       valid_in;
   logic [bedbm_pkg::DP_W-1:0] d_ff;
   logic                       load;
   logic                       active;
   logic [bedbm_pkg::DP_W-1:0] sub_v;
   logic [bedbm_pkg::DP_W-1:0] up_v;
   logic [bedbm_pkg::DP_W-1:0] left_v;
   logic [bedbm_pkg::DP_W-1:0] v;
   bedbm_pkg::link_type        link_ff;
   bedbm_pkg::link_type        link_in_nx;

   assign load     = qwr_en && (qwr_idx == bedbm_pkg::IDX_W'(index - 1'b1));
   assign valid_in = qclr ? load : (valid_ff | load);
   assign active   = valid_ff && link_in.tok;

   always_comb begin
      sub_v  = link_in.diag + ((q_ff != cand_char) ? bedbm_pkg::DP_W'(1) : '0);
      up_v   = d_ff + 1'b1;
      left_v = link_in.left + 1'b1;
      v      = up_v;
      if (left_v < v) begin
         v = left_v;
      end
      if (sub_v < v) begin
         v = sub_v;
      end
   end

   always_comb begin
      link_in_nx.tok  = link_in.tok;
      link_in_nx.diag = d_ff;
      link_in_nx.left = active ? v : link_in.left;
      link_in_nx.rmin = (active && v < link_in.rmin) ? v : link_in.rmin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         link_ff.tok <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         link_ff.tok <= link_in_nx.tok;
      end
      if (load) begin
         q_ff <= qwr_data;
      end
      if (init) begin
         d_ff <= index;
      end else if (active) begin
         d_ff <= v;
      end
      link_ff.left <= link_in_nx.left;
      link_ff.diag <= link_in_nx.diag;
      link_ff.rmin <= link_in_nx.rmin;
   end

   assign link_out = link_ff;

endmodule

[rtl/core/bounded_edit_distance_best_match.sv]
// ----------------------------------------------------------------------------
// bounded_edit_distance_best_match
// closest name search under a bounded edit distance against a loaded query
// ----------------------------------------------------------------------------
//  channel | direction | ports                                  | handshake
//  req     | in        | opcode character first/last_char tag   | valid/stall
//  rsp     | out       | suggestion best_tag/distance tie bound | valid/stall
//
//  query and report beats leave the state machine in its idle state
//  a swept candidate beat passes a memory read, a flag step and a sweep in which
//  a token runs through the MAX_LEN cells, one cell a cycle; a beat of an
//  abandoned or overlong candidate skips the sweep; a last beat adds a commit
//  synchronous reset clears control state; memories stay undefined until written
//  every beat stalls while a candidate beat is in flight, and a report beat also
//  while an earlier report still waits on rsp
// ----------------------------------------------------------------------------
module bounded_edit_distance_best_match (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_character,
   input  logic        req_first_char,
   input  logic        req_last_char,
   input  logic [15:0] req_candidate_tag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_suggestion_valid,
   output logic [15:0] rsp_best_tag,
   output logic [6:0]  rsp_best_distance,
   output logic [7:0]  rsp_tie_count,
   output logic [6:0]  rsp_distance_bound
);

   localparam int ML = bedbm_pkg::MAX_LEN;
   localparam int LW = bedbm_pkg::LEN_W;
   localparam int DW = bedbm_pkg::DP_W;
   localparam int IW = bedbm_pkg::IDX_W;
   localparam int MW = bedbm_pkg::LIM_W;

   bedbm_pkg::state_type state_ff, state_in;

   logic [7:0] qmem [ML];
   logic [7:0] nbuf [2*ML];
   logic [7:0] qrd_ff;
   logic [7:0] nrd_ff;

   logic [LW-1:0] q_len_ff;
   logic [1:0]    q_mod_ff;
   logic          q_ovf_ff;
   logic [MW-1:0] limit_ff;
   logic          q0us_ff;
   logic          qus_ff;

   logic [LW-1:0] cand_len_ff;
   logic          active_ff, exact_ff, fold_ff, inv_ff, opr_ff, aband_ff, bmiss_ff;
   logic          us0_ff, us1_ff;
   logic [15:0]   tag_ff;
   logic [LW-1:0] pos_ff;
   logic [7:0]    char_ff;
   logic          last_ff;
   logic [DW-1:0] d0_ff;
   logic [DW-1:0] dist_ff;

   logic          best_sel_ff;
   logic [LW-1:0] best_len_ff;
   logic [15:0]   best_tag_ff;
   logic [MW-1:0] best_dist_ff;
   logic          best_valid_ff;
   logic [7:0]    tie_ff;

   logic          rsp_valid_ff;
   logic          rsp_sugg_ff;
   logic [15:0]   rsp_tag_ff;
   logic [6:0]    rsp_dist_ff;
   logic [7:0]    rsp_tie_ff;
   logic [6:0]    rsp_bound_ff;

   bedbm_pkg::link_type launch_ff;
   bedbm_pkg::link_type links [ML+1];

   logic          req_acc;
   logic          acc_query, acc_cand, acc_report;
   logic          cand_go;
   logic [LW-1:0] qidx;
   logic          qwr_en;
   logic [LW-1:0] pos_sel;
   logic [1:0]    mod_nx;
   logic          sweep;
   logic          end_tok;
   logic          in_q;
   logic          rej;
   logic          zero_hit;
   logic [DW-1:0] cdist;
   logic [DW-1:0] lim_ext;

   assign req_stall  = (state_ff != bedbm_pkg::IDLE_S) ||
                       (req_opcode == bedbm_pkg::OP_REPORT && rsp_valid_ff && rsp_stall);
   assign req_acc    = req_valid && !req_stall;
   assign acc_query  = req_acc && req_opcode == bedbm_pkg::OP_QUERY;
   assign acc_cand   = req_acc && req_opcode == bedbm_pkg::OP_CAND;
   assign acc_report = req_acc && req_opcode == bedbm_pkg::OP_REPORT;
   assign cand_go    = acc_cand && (req_first_char || active_ff);

   assign qidx    = req_first_char ? '0 : q_len_ff;
   assign qwr_en  = acc_query && qidx < LW'(ML);
   assign mod_nx  = req_first_char ? 2'd1 : ((q_mod_ff == 2'd2) ? 2'd0 : q_mod_ff + 2'd1);
   assign pos_sel = req_first_char ? '0 : cand_len_ff;

   assign in_q    = pos_ff < q_len_ff;
   assign sweep   = !aband_ff && pos_ff < LW'(ML);
   assign end_tok = links[ML].tok;
   assign lim_ext = DW'(limit_ff);

   always_comb begin
      rej = (limit_ff == '0) || q_ovf_ff || cand_len_ff > LW'(ML) ||
            (cand_len_ff >= LW'(bedbm_pkg::INV_LEN) && !inv_ff) ||
            (cand_len_ff >= LW'(bedbm_pkg::OPR_LEN) && !opr_ff) ||
            (cand_len_ff == q_len_ff && !exact_ff) ||
            (cand_len_ff >= LW'(2) && us0_ff && us1_ff && !qus_ff);
      zero_hit = cand_len_ff == q_len_ff && !fold_ff;
      cdist    = zero_hit ? '0 : dist_ff;
      if (!zero_hit && (aband_ff || dist_ff > lim_ext)) begin
         rej = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bedbm_pkg::IDLE_S: begin
            if (cand_go) begin
               state_in = bedbm_pkg::FLAG_S;
            end
         end
         bedbm_pkg::FLAG_S: begin
            if (sweep) begin
               state_in = bedbm_pkg::SWEEP_S;
            end else if (last_ff) begin
               state_in = bedbm_pkg::COMMIT_S;
            end else begin
               state_in = bedbm_pkg::IDLE_S;
            end
         end
         bedbm_pkg::SWEEP_S: begin
            if (end_tok) begin
               state_in = last_ff ? bedbm_pkg::COMMIT_S : bedbm_pkg::IDLE_S;
            end
         end
         bedbm_pkg::COMMIT_S: begin
            state_in = bedbm_pkg::IDLE_S;
         end
         default: begin
            state_in = bedbm_pkg::IDLE_S;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (qwr_en) begin
         qmem[qidx[IW-1:0]] <= req_character;
      end
      if (cand_go && pos_sel < LW'(ML)) begin
         nbuf[{~best_sel_ff, pos_sel[IW-1:0]}] <= req_character;
      end
      qrd_ff <= qmem[pos_sel[IW-1:0]];
      nrd_ff <= nbuf[{best_sel_ff, pos_sel[IW-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bedbm_pkg::IDLE_S;
         q_len_ff      <= '0;
         q_mod_ff      <= '0;
         q_ovf_ff      <= 1'b0;
         limit_ff      <= '0;
         qus_ff        <= 1'b0;
         cand_len_ff   <= '0;
         active_ff     <= 1'b0;
         aband_ff      <= 1'b0;
         best_sel_ff   <= 1'b0;
         best_len_ff   <= '0;
         best_tag_ff   <= '0;
         best_dist_ff  <= '0;
         best_valid_ff <= 1'b0;
         tie_ff        <= '0;
         launch_ff.tok <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff.tok <= 1'b0;
         if (acc_report) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            bedbm_pkg::IDLE_S: begin
               if (acc_query) begin
                  if (qwr_en) begin
                     q_len_ff <= qidx + 1'b1;
                     q_mod_ff <= mod_nx;
                     if (req_first_char) begin
                        limit_ff <= MW'(1);
                     end else if (mod_nx == 2'd1) begin
                        limit_ff <= limit_ff + 1'b1;
                     end
                     if (qidx == '0) begin
                        qus_ff <= 1'b0;
                     end else if (qidx == LW'(1)) begin
                        qus_ff <= q0us_ff && req_character == bedbm_pkg::CH_UNDER;
                     end
                     q_ovf_ff <= req_first_char ? 1'b0 : q_ovf_ff;
                  end else begin
                     q_ovf_ff <= 1'b1;
                  end
                  best_valid_ff <= 1'b0;
                  best_tag_ff   <= '0;
                  best_dist_ff  <= '0;
                  best_len_ff   <= '0;
                  tie_ff        <= '0;
                  active_ff     <= 1'b0;
                  aband_ff      <= 1'b0;
                  cand_len_ff   <= '0;
               end else if (cand_go && req_first_char) begin
                  active_ff   <= 1'b1;
                  aband_ff    <= 1'b0;
                  cand_len_ff <= '0;
               end
            end
            bedbm_pkg::FLAG_S: begin
               if (pos_ff <= LW'(ML)) begin
                  cand_len_ff <= pos_ff + 1'b1;
               end
               if (sweep) begin
                  launch_ff.tok  <= 1'b1;
                  launch_ff.left <= DW'(pos_ff) + 1'b1;
                  launch_ff.diag <= d0_ff;
                  launch_ff.rmin <= DW'(pos_ff) + 1'b1;
               end
            end
            bedbm_pkg::SWEEP_S: begin
               if (end_tok && links[ML].rmin > lim_ext) begin
                  aband_ff <= 1'b1;
               end
            end
            bedbm_pkg::COMMIT_S: begin
               active_ff <= 1'b0;
               aband_ff  <= 1'b0;
               if (!rej) begin
                  if (!best_valid_ff || cdist < DW'(best_dist_ff)) begin
                     best_valid_ff <= 1'b1;
                     best_dist_ff  <= MW'(cdist);
                     best_tag_ff   <= tag_ff;
                     best_sel_ff   <= ~best_sel_ff;
                     best_len_ff   <= cand_len_ff;
                     tie_ff        <= 8'd1;
                  end else if (cdist == DW'(best_dist_ff)) begin
                     if ((cand_len_ff != best_len_ff || bmiss_ff) && tie_ff != 8'hff) begin
                        tie_ff <= tie_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               active_ff <= 1'b0;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (qwr_en && qidx == '0) begin
         q0us_ff <= req_character == bedbm_pkg::CH_UNDER;
      end
      if (cand_go) begin
         pos_ff  <= pos_sel;
         char_ff <= req_character;
         last_ff <= req_last_char;
         if (req_first_char) begin
            tag_ff   <= req_candidate_tag;
            d0_ff    <= '0;
            exact_ff <= 1'b0;
            fold_ff  <= 1'b0;
            inv_ff   <= 1'b0;
            opr_ff   <= 1'b0;
            bmiss_ff <= 1'b0;
            us0_ff   <= 1'b0;
            us1_ff   <= 1'b0;
         end
      end
      if (state_ff == bedbm_pkg::FLAG_S) begin
         if (!in_q || qrd_ff != char_ff) begin
            exact_ff <= 1'b1;
         end
         if (!in_q || bedbm_pkg::fold(qrd_ff) != bedbm_pkg::fold(char_ff)) begin
            fold_ff <= 1'b1;
         end
         if (pos_ff < LW'(bedbm_pkg::INV_LEN) &&
             bedbm_pkg::INV_PREFIX[pos_ff[3:0]] != char_ff) begin
            inv_ff <= 1'b1;
         end
         if (pos_ff < LW'(bedbm_pkg::OPR_LEN) &&
             bedbm_pkg::OPR_PREFIX[pos_ff[2:0]] != char_ff) begin
            opr_ff <= 1'b1;
         end
         if (pos_ff >= best_len_ff || nrd_ff != char_ff) begin
            bmiss_ff <= 1'b1;
         end
         if (pos_ff == '0) begin
            us0_ff <= char_ff == bedbm_pkg::CH_UNDER;
         end
         if (pos_ff == LW'(1)) begin
            us1_ff <= char_ff == bedbm_pkg::CH_UNDER;
         end
         if (sweep) begin
            d0_ff <= DW'(pos_ff) + 1'b1;
         end
      end
      if (state_ff == bedbm_pkg::SWEEP_S && end_tok) begin
         dist_ff <= links[ML].left;
      end
      if (acc_report) begin
         rsp_sugg_ff  <= best_valid_ff && tie_ff == 8'd1 && !q_ovf_ff;
         rsp_tag_ff   <= best_valid_ff ? best_tag_ff : '0;
         rsp_dist_ff  <= best_valid_ff ? 7'(best_dist_ff) : '0;
         rsp_tie_ff   <= tie_ff;
         rsp_bound_ff <= 7'(limit_ff);
      end
   end

   assign links[0] = launch_ff;

   for (genvar j = 1; j <= ML; j++) begin : g_cell
      bedbm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .index     (DW'(j)),
         .qwr_en    (qwr_en),
         .qwr_idx   (qidx[IW-1:0]),
         .qclr      (acc_query && req_first_char),
         .qwr_data  (req_character),
         .init      (cand_go && req_first_char),
         .cand_char (char_ff),
         .link_in   (links[j-1]),
         .link_out  (links[j])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_suggestion_valid = rsp_sugg_ff;
   assign rsp_best_tag         = rsp_tag_ff;
   assign rsp_best_distance    = rsp_dist_ff;
   assign rsp_tie_count        = rsp_tie_ff;
   assign rsp_distance_bound   = rsp_bound_ff;

   a_tie_needs_best: assert property (@(posedge clock) disable iff (reset)
      tie_ff != 8'd0 |-> best_valid_ff)
      else $error("tie count without a best candidate");

   a_best_in_bound: assert property (@(posedge clock) disable iff (reset)
      best_valid_ff |-> best_dist_ff <= limit_ff)
      else $error("best distance above bound");

   a_token_in_sweep: assert property (@(posedge clock) disable iff (reset)
      end_tok |-> state_ff == bedbm_pkg::SWEEP_S)
      else $error("row token left the chain outside a sweep");

endmodule
